// File: rtl/wsf_pkg.sv
// Shared types, constants and tables for the wave superposition field block.
package wsf_pkg;

	localparam int MAX_SOURCES  = 1024;
	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W        = $clog2(MAX_SOURCES + 1);
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 40;   // CORDIC x/y width
	localparam int ZW           = 33;   // CORDIC angle width
	localparam int MOD_W        = 52;   // dividend width of the phase reduction
	localparam int MOD_STEPS    = 4;    // quotient, multiply-subtract, two corrections
	localparam int MOD_CNT_W    = $clog2(MOD_STEPS);
	localparam int DIST_SPLIT   = 20;

	localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
	// floor(2^52 / TWO_PI_Q28), applied to the top 32 bits of the dividend
	localparam logic [21:0] RECIP_TWO_PI = 22'd2670176;
	localparam logic signed [ZW-1:0] PI_Q28      = 33'sd843314857;
	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic signed [CW-1:0] INV_GAIN_Q28 = 40'sd163008219;

	localparam int REG_ADDR_W = 5;
	localparam logic [2:0] REG_SOURCE_X       = 3'd0;
	localparam logic [2:0] REG_SOURCE_Y_FIRST = 3'd1;
	localparam logic [2:0] REG_SOURCE_Y_STEP  = 3'd2;
	localparam logic [2:0] REG_SOURCE_COUNT   = 3'd3;
	localparam logic [2:0] REG_AMPLITUDE      = 3'd4;
	localparam logic [2:0] REG_WAVENUMBER     = 3'd5;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] field_value;
		logic               saturated;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_VEC, ST_DIST, ST_MUL1, ST_MOD1,
		ST_MUL2, ST_MOD2, ST_MAP, ST_ROT, ST_TERM, ST_ACC
	} state_t;

	function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd210828714;
			5'd1:  v = 32'd124459457;
			5'd2:  v = 32'd65760959;
			5'd3:  v = 32'd33381290;
			5'd4:  v = 32'd16755422;
			5'd5:  v = 32'd8385879;
			5'd6:  v = 32'd4193963;
			5'd7:  v = 32'd2097109;
			5'd8:  v = 32'd1048571;
			5'd9:  v = 32'd524287;
			5'd29, 5'd30, 5'd31: v = 32'd0;
			default: v = 32'd1 << (5'd28 - i);
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

// File: rtl/wave_superposition_field_top.sv
// Top level of the wave superposition field block: registers, sequencer and datapath.
//
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// input     | start / busy         | item (point_x, point_y)
// result    | done (1-cycle pulse) | result (field_value, saturated)
// config    | APB psel/penable     | paddr, pwdata, prdata
//
// One shared CORDIC step and one remainder unit do all the work. The remainder
// unit estimates the quotient by a reciprocal multiply, subtracts quotient * 2*pi
// and applies two compare-and-subtract corrections. Each source passes through
// load, vectoring, distance, multiply and reduce twice, fold, rotation, term and
// accumulate; done is raised once min(source_count, 1024) sources have been
// accumulated, and busy drops in that same cycle. A zero count raises done in
// the cycle after accept.
// Reset clears the registers to their defaults and the sequencer to idle.
// The receiver cannot stall: the result is shown for the one cycle done is high.
module wave_superposition_field_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  wsf_pkg::in_item_t      item,
	output logic                   done,
	output wsf_pkg::out_item_t     result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [wsf_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import wsf_pkg::*;

	// configuration registers
	logic signed [23:0] source_x_q, source_y_first_q;
	logic [22:0]        source_y_step_q;
	logic [10:0]        source_count_q;
	logic signed [15:0] amplitude_q;
	logic [23:0]        wavenumber_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[REG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_x_q       <= '0;
			source_y_first_q <= '0;
			source_y_step_q  <= 23'd4096;
			source_count_q   <= 11'd1;
			amplitude_q      <= 16'sd4096;
			wavenumber_q     <= 24'd65536;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SOURCE_X:       source_x_q       <= pwdata[23:0];
				REG_SOURCE_Y_FIRST: source_y_first_q <= pwdata[23:0];
				REG_SOURCE_Y_STEP:  source_y_step_q  <= pwdata[22:0];
				REG_SOURCE_COUNT:   source_count_q   <= pwdata[10:0];
				REG_AMPLITUDE:      amplitude_q      <= pwdata[15:0];
				REG_WAVENUMBER:     wavenumber_q     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SOURCE_X:       prdata = {8'd0, source_x_q};
			REG_SOURCE_Y_FIRST: prdata = {8'd0, source_y_first_q};
			REG_SOURCE_Y_STEP:  prdata = {9'd0, source_y_step_q};
			REG_SOURCE_COUNT:   prdata = {21'd0, source_count_q};
			REG_AMPLITUDE:      prdata = {16'd0, amplitude_q};
			REG_WAVENUMBER:     prdata = {8'd0, wavenumber_q};
			default:            prdata = '0;
		endcase
	end

	// sequencer and datapath state
	state_t state_q, state_d;

	logic signed [23:0]    py_q;
	logic signed [24:0]    dx_q;
	logic signed [35:0]    yj_q;
	logic [CNT_W-1:0]      j_q, n_q;
	logic [STEP_W-1:0]     it_q;
	logic signed [CW-1:0]  cx_q, cy_q;
	logic signed [ZW-1:0]  cz_q;
	logic [36:0]           d_q;
	logic [MOD_W-1:0]      sr_q;
	logic [21:0]           quo_q;
	logic [MOD_CNT_W-1:0]  mcnt_q;
	logic signed [19:0]    term_q;
	logic signed [47:0]    acc_q;
	logic                  done_q;
	out_item_t             result_q;

	logic signed [CW-1:0] cx_n, cy_n;
	logic signed [ZW-1:0] cz_n;

	wsf_cordic_step u_cordic (
		.x      (cx_q),
		.y      (cy_q),
		.z      (cz_q),
		.rotate (state_q == ST_ROT),
		.shift  (5'(it_q)),
		.x_next (cx_n),
		.y_next (cy_n),
		.z_next (cz_n)
	);

	logic accept, last_it, last_mod, last_src;
	logic [CNT_W-1:0] n_clamp;

	assign accept   = start && !busy;
	assign last_it  = (it_q == STEP_W'(CORDIC_STEPS - 1));
	assign last_mod = (mcnt_q == MOD_CNT_W'(MOD_STEPS - 1));
	assign last_src = (j_q + 1'b1 == n_q);
	assign n_clamp  = (source_count_q > 11'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
	                                                     : CNT_W'(source_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: if (accept && n_clamp != '0) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_VEC;
			ST_VEC:  if (last_it) state_d = ST_DIST;
			ST_DIST: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MOD1;
			ST_MOD1: if (last_mod) state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MOD2;
			ST_MOD2: if (last_mod) state_d = ST_MAP;
			ST_MAP:  state_d = ST_ROT;
			ST_ROT:  if (last_it) state_d = ST_TERM;
			ST_TERM: state_d = ST_ACC;
			ST_ACC:  state_d = last_src ? ST_IDLE : ST_LOAD;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath combinational helpers
	logic signed [36:0] dy;
	logic [38:0]        xx;
	logic [55:0]        dist_full;
	logic [53:0]        quo_full;
	logic signed [ZW-1:0] ph, ph_w;
	logic signed [47:0] prod_amp;
	logic signed [47:0] sum_next;

	always_comb begin
		dy        = 37'(py_q) - 37'(yj_q);
		xx        = cx_q[CW-1] ? '0 : cx_q[38:0];
		dist_full = 56'(xx) * 56'(INV_GAIN_Q16) + 56'd32768;
		// quotient estimate from the top 32 bits: low by at most two
		quo_full  = 54'(sr_q[MOD_W-1:MOD_W-32]) * 54'(RECIP_TWO_PI);
		ph        = $signed({2'b00, sr_q[30:0]});
		if (ph > PI_Q28) ph = ph - $signed({2'b00, TWO_PI_Q28});
		if (ph > HALF_PI_Q28)       ph_w = PI_Q28 - ph;
		else if (ph < -HALF_PI_Q28) ph_w = -PI_Q28 - ph;
		else                        ph_w = ph;
		prod_amp  = 48'(amplitude_q) * 48'($signed(cy_q[31:0])) + 48'sd134217728;
		sum_next  = acc_q + 48'(term_q);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				py_q  <= item.point_y;
				dx_q  <= 25'(item.point_x) - 25'(source_x_q);
				yj_q  <= 36'(source_y_first_q);
				j_q   <= '0;
				n_q   <= n_clamp;
				acc_q <= '0;
			end
			ST_LOAD: begin
				cx_q <= dx_q[24] ? -CW'(dx_q) : CW'(dx_q);
				cy_q <= dy[36] ? -CW'(dy) : CW'(dy);
				cz_q <= '0;
				it_q <= '0;
			end
			ST_VEC, ST_ROT: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
				it_q <= it_q + 1'b1;
			end
			ST_DIST: d_q <= dist_full[52:16];
			ST_MUL1: begin
				// k * high part of distance, then reduce mod 2*pi
				sr_q   <= MOD_W'(wavenumber_q) * MOD_W'(d_q[36:DIST_SPLIT]);
				mcnt_q <= '0;
			end
			ST_MOD1, ST_MOD2: begin
				case (mcnt_q)
					MOD_CNT_W'(0): quo_q <= quo_full[53:32];
					MOD_CNT_W'(1): sr_q  <= sr_q - MOD_W'(quo_q) * MOD_W'(TWO_PI_Q28);
					default: begin
						if (sr_q >= MOD_W'(TWO_PI_Q28))
							sr_q <= sr_q - MOD_W'(TWO_PI_Q28);
					end
				endcase
				mcnt_q <= mcnt_q + 1'b1;
			end
			ST_MUL2: begin
				sr_q   <= {sr_q[30:0], 20'd0} +
				          MOD_W'(wavenumber_q) * MOD_W'(d_q[DIST_SPLIT-1:0]);
				mcnt_q <= '0;
			end
			ST_MAP: begin
				cx_q <= INV_GAIN_Q28;
				cy_q <= '0;
				cz_q <= ph_w;
				it_q <= '0;
			end
			ST_TERM: term_q <= 20'(prod_amp >>> 28);
			ST_ACC: begin
				acc_q <= sum_next;
				j_q   <= j_q + 1'b1;
				yj_q  <= yj_q + 36'(source_y_step_q);
			end
			default: ;
		endcase
	end

	// result register: pulse done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_ACC && last_src) ||
			          (state_q == ST_IDLE && accept && n_clamp == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			result_q.field_value <= '0;
			result_q.saturated   <= 1'b0;
		end else if (state_q == ST_ACC) begin
			if (sum_next > 48'sd2147483647) begin
				result_q.field_value <= 32'sh7fffffff;
				result_q.saturated   <= 1'b1;
			end else if (sum_next < -48'sd2147483648) begin
				result_q.field_value <= 32'sh80000000;
				result_q.saturated   <= 1'b1;
			end else begin
				result_q.field_value <= sum_next[31:0];
				result_q.saturated   <= 1'b0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/wsf_cordic_step.sv
// One CORDIC micro-rotation, vectoring or rotation mode.
module wsf_cordic_step (
	input  logic signed [wsf_pkg::CW-1:0] x,
	input  logic signed [wsf_pkg::CW-1:0] y,
	input  logic signed [wsf_pkg::ZW-1:0] z,
	input  logic                          rotate,
	input  logic [4:0]                    shift,
	output logic signed [wsf_pkg::CW-1:0] x_next,
	output logic signed [wsf_pkg::CW-1:0] y_next,
	output logic signed [wsf_pkg::ZW-1:0] z_next
);
	import wsf_pkg::*;

	logic signed [CW-1:0] xs, ys;
	logic                 pos;

	always_comb begin
		xs  = x >>> shift;
		ys  = y >>> shift;
		pos = rotate ? !z[ZW-1] : !y[CW-1];
		if (pos ^ !rotate) begin
			// rotate toward positive angle
			x_next = x - ys;
			y_next = y + xs;
			z_next = z - atan_q28(shift);
		end else begin
			x_next = x + ys;
			y_next = y - xs;
			z_next = z + atan_q28(shift);
		end
	end

endmodule

// File: dv/wave_superposition_field_top_test.sv
// Testbench for the wave superposition field block: APB setup, point stimulus, scoreboard.
`timescale 1ns / 1ps

class field_scoreboard;
	// register copies, as the block holds them
	logic signed [23:0] src_x;
	logic signed [23:0] src_y_first;
	logic [22:0]        src_y_step;
	logic [10:0]        src_count;
	logic signed [15:0] amp;
	logic [23:0]        wave_k;

	wsf_pkg::out_item_t expected_fields[$];
	int                 mismatches;
	longint             arctan[16];

	function new();
		arctan = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
			4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
			16384, 8192};
		src_x       = '0;
		src_y_first = '0;
		src_y_step  = 23'd4096;
		src_count   = 11'd1;
		amp         = 16'sd4096;
		wave_k      = 24'd65536;
		mismatches  = 0;
	endfunction

	// Mirror an APB write; unused addresses drop the data.
	function void note_write(logic [wsf_pkg::REG_ADDR_W-1:0] addr, logic [31:0] data);
		case (addr[4:2])
			wsf_pkg::REG_SOURCE_X:       src_x       = data[23:0];
			wsf_pkg::REG_SOURCE_Y_FIRST: src_y_first = data[23:0];
			wsf_pkg::REG_SOURCE_Y_STEP:  src_y_step  = data[22:0];
			wsf_pkg::REG_SOURCE_COUNT:   src_count   = data[10:0];
			wsf_pkg::REG_AMPLITUDE:      amp         = data[15:0];
			wsf_pkg::REG_WAVENUMBER:     wave_k      = data[23:0];
			default: ;
		endcase
	endfunction

	// Vectoring CORDIC magnitude, gain-corrected, Q13.12.
	function longint unsigned source_distance(longint dx, longint dy);
		longint x, y, xs, ys;
		longint unsigned ux;
		x = (dx < 0) ? -dx : dx;
		y = (dy < 0) ? -dy : dy;
		for (int i = 0; i < wsf_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
			end else begin
				x = x - ys;
				y = y + xs;
			end
		end
		if (x < 0)
			x = 0;
		ux = x;
		return (ux * 64'd39797 + 64'd32768) >> 16;
	endfunction

	// Phase k*d reduced modulo 2*pi and folded into [-pi/2, pi/2], Q.28.
	function longint folded_phase(longint unsigned d);
		longint unsigned two_pi, r, k;
		longint p;
		two_pi = 64'd1686629713;
		k = wave_k;
		r = (k * (d >> 20)) % two_pi;
		r = ((r << 20) + k * (d & 64'hFFFFF)) % two_pi;
		p = r;
		if (p > 64'sd843314857)
			p = p - 64'sd1686629713;
		if (p > 64'sd421657428)
			p = 64'sd843314857 - p;
		else if (p < -64'sd421657428)
			p = -64'sd843314857 - p;
		return p;
	endfunction

	// Rotation CORDIC sine, Q.28.
	function longint phase_sine(longint z);
		longint x, y, xs, ys;
		x = 64'sd163008219;
		y = 0;
		for (int i = 0; i < wsf_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan[i];
			end
		end
		return y;
	endfunction

	function wsf_pkg::out_item_t field_at(wsf_pkg::in_item_t pt);
		wsf_pkg::out_item_t res;
		longint dx, dy, s, sum, a, n;
		dx  = longint'(pt.point_x) - longint'(src_x);
		a   = amp;
		sum = 0;
		n   = (src_count > wsf_pkg::MAX_SOURCES) ? wsf_pkg::MAX_SOURCES : src_count;
		for (longint j = 0; j < n; j++) begin
			dy  = longint'(pt.point_y) - (longint'(src_y_first) + j * longint'(src_y_step));
			s   = phase_sine(folded_phase(source_distance(dx, dy)));
			sum = sum + ((a * s + (64'sd1 <<< 27)) >>> 28);
		end
		res.saturated = 1'b0;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			res.saturated = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			res.saturated = 1'b1;
		end
		res.field_value = sum[31:0];
		return res;
	endfunction

	function void note_point(wsf_pkg::in_item_t pt);
		expected_fields.push_back(field_at(pt));
	endfunction

	function void check_result(wsf_pkg::out_item_t got);
		wsf_pkg::out_item_t want;
		if (expected_fields.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: field_value=%0d saturated=%0b",
					got.field_value, got.saturated);
			return;
		end
		want = expected_fields.pop_front();
		if (got.field_value !== want.field_value || got.saturated !== want.saturated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: field_value exp %0d got %0d, saturated exp %0b got %0b",
					want.field_value, got.field_value, want.saturated, got.saturated);
		end
	endfunction

	function int pending();
		return expected_fields.size();
	endfunction
endclass

module wave_superposition_field_top_test;
	import wsf_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_item_t              item;
	logic                  done;
	out_item_t             result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	field_scoreboard sb;

	wave_superposition_field_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Check every result in the one cycle it is shown; the receiver never stalls.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Hold a point until the block takes it, then note the transaction.
	task automatic send_point(input logic [23:0] x, input logic [23:0] y);
		in_item_t pt;
		repeat ($urandom_range(0, 19)) @(negedge clk);
		pt.point_x = x;
		pt.point_y = y;
		item  = pt;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_point(pt);
		@(negedge clk);
		start = 1'b0;
		item  = '{point_x: 24'($urandom), point_y: 24'($urandom)};
	endtask

	// APB write with setup and access phases; pready is always high, so the access phase ends at once.
	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.note_write(addr, data);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Drain: every point yields one result, so an empty queue means idle.
	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sources(input logic [23:0] sx, input logic [23:0] sy0,
			input logic [22:0] stp, input logic [10:0] cnt,
			input logic [15:0] a, input logic [23:0] k);
		write_reg({REG_SOURCE_X, 2'b00}, {8'd0, sx});
		write_reg({REG_SOURCE_Y_FIRST, 2'b00}, {8'd0, sy0});
		write_reg({REG_SOURCE_Y_STEP, 2'b00}, {9'd0, stp});
		write_reg({REG_SOURCE_COUNT, 2'b00}, {21'd0, cnt});
		write_reg({REG_AMPLITUDE, 2'b00}, {16'd0, a});
		write_reg({REG_WAVENUMBER, 2'b00}, {8'd0, k});
	endtask

	initial begin
		logic [23:0] px;
		logic [23:0] py;
		sb      = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults: origin, coordinate extremes, all-ones and alternating bits.
		send_point(24'h000000, 24'h000000);
		send_point(24'h800000, 24'h800000);
		send_point(24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'h7FFFFF);
		send_point(24'hFFFFFF, 24'h555555);
		send_point(24'h001000, 24'hAAAAAA);
		wait_drained();

		// Zero source count returns an empty sum.
		write_reg({REG_SOURCE_COUNT, 2'b00}, 32'd0);
		send_point(24'h123456, 24'h654321);
		wait_drained();

		// Unused addresses must leave every register alone.
		write_reg(5'd24, 32'hFFFFFFFF);
		write_reg(5'd28, 32'hFFFFFFFF);
		send_point(24'h000100, 24'hFFF000);
		wait_drained();

		// Register extremes, few sources.
		set_sources(24'h800000, 24'h7FFFFF, 23'h7FFFFF, 11'd3, 16'h8000, 24'hFFFFFF);
		send_point(24'h7FFFFF, 24'h800000);
		send_point(24'h000000, 24'h000000);
		wait_drained();
		set_sources(24'h7FFFFF, 24'h800000, 23'd0, 11'd4, 16'h7FFF, 24'd0);
		send_point(24'h800000, 24'h7FFFFF);
		send_point(24'h7FFFFF, 24'h800000);
		wait_drained();
		set_sources(24'h000000, 24'h800000, 23'd1, 11'd2, 16'h7FFF, 24'hFFFFFF);
		send_point(24'h000000, 24'h800000);
		send_point(24'h000001, 24'h800001);
		wait_drained();

		// Largest count, then a count above the source limit (clamped).
		set_sources(24'h000000, 24'hE00000, 23'h000800, 11'd1024, 16'h7FFF, 24'h012345);
		send_point(24'h010000, 24'h000000);
		wait_drained();
		write_reg({REG_SOURCE_COUNT, 2'b00}, 32'd2047);
		send_point(24'hFF0000, 24'h100000);
		wait_drained();

		// Random phases: random registers, small counts, full-range points.
		for (int ph = 0; ph < 8; ph++) begin
			set_sources(24'($urandom), 24'($urandom),
				($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 65536)),
				11'($urandom_range(1, 6)), 16'($urandom), 24'($urandom));
			for (int n = 0; n < 12; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					// near the source row, where distances are short
					px = sb.src_x + 24'($signed(14'($urandom)));
					py = sb.src_y_first + 24'($signed(16'($urandom)));
				end else begin
					px = 24'($urandom);
					py = 24'($urandom);
				end
				send_point(px, py);
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Backstop for a hung handshake.
	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end
endmodule
